@@ hw/rtl/fba_pkg.sv @@
// Shared types and constants for the fixed block allocator.
`timescale 1ns / 1ps

package fba_pkg;

	localparam int MAX_BLOCKS = 64;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = 7;
	localparam int ADDR_W     = 32;
	localparam int SIZE_W     = 16;
	localparam int ACC_W      = ADDR_W + 1;

	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_ALLOC = 2'd1;
	localparam logic [1:0] MODE_FREE  = 2'd2;

	localparam logic [1:0] REG_BASE  = 2'd0;
	localparam logic [1:0] REG_SIZE  = 2'd1;
	localparam logic [1:0] REG_COUNT = 2'd2;

	localparam logic [ADDR_W-1:0] RST_BASE  = '0;
	localparam logic [SIZE_W-1:0] RST_SIZE  = SIZE_W'(16);
	localparam logic [CNT_W-1:0]  RST_COUNT = CNT_W'(64);

	typedef struct packed {
		logic start;
		logic step;
		logic finish;
	} fba_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_busy;
	} fba_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} fba_state_t;

endpackage

@@ hw/rtl/fba_ctrl.sv @@
// Controller state machine: accept, scan, commit.
`timescale 1ns / 1ps

module fba_ctrl import fba_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  fba_stat_t stat,
	output fba_cmd_t  cmd
);

	fba_state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		req_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.scan_done) begin
					state_d = ST_FINISH;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_FINISH: begin
				if (!stat.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hw/rtl/fba_datapath.sv @@
// Datapath: config registers, used flags, scan unit and result register.
`timescale 1ns / 1ps

module fba_datapath import fba_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [1:0]        cfg_index,
	input  logic [ADDR_W-1:0] cfg_data,
	input  logic [1:0]        req_mode,
	input  logic [ADDR_W-1:0] req_address,
	input  fba_cmd_t          cmd,
	output fba_stat_t         stat,
	input  logic              out_ready,
	output logic              out_valid,
	output logic              out_status,
	output logic [ADDR_W-1:0] out_block_address,
	output logic [CNT_W-1:0]  out_free_count,
	output logic              out_in_region
);

	logic [ADDR_W-1:0]     base_q;
	logic [SIZE_W-1:0]     size_q;
	logic [CNT_W-1:0]      count_q;
	logic [MAX_BLOCKS-1:0] used_q;

	logic [1:0]        mode_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CNT_W-1:0]  idx_q;
	logic [ACC_W-1:0]  acc_q;
	logic [CNT_W-1:0]  nfree_q;
	logic              found_q;
	logic              hit_used_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [ADDR_W-1:0] hit_addr_q;

	logic              out_valid_q;
	logic              out_status_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [CNT_W-1:0]  out_count_q;
	logic              out_region_q;

	logic [CNT_W-1:0] n_active;
	logic             cur_used;
	logic             hit;
	logic             res_status;
	logic [ADDR_W-1:0] res_addr;
	logic [CNT_W-1:0] res_count;
	logic             res_region;

	// active block count, capped at the built capacity
	assign n_active = (count_q > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : count_q;
	assign cur_used = used_q[idx_q[IDX_W-1:0]];

	always_comb begin
		hit = 1'b0;
		case (mode_q)
			MODE_ALLOC: hit = !found_q && !cur_used;
			MODE_FREE:  hit = !found_q && (acc_q[ADDR_W-1:0] == addr_q);
			default:    hit = 1'b0;
		endcase
	end

	assign stat.scan_done = (idx_q == n_active);
	assign stat.out_busy  = out_valid_q && !out_ready;

	// result of the finished scan
	always_comb begin
		res_status = 1'b1;
		res_addr   = '0;
		res_count  = nfree_q;
		case (mode_q)
			MODE_CLEAR: begin
				res_status = 1'b0;
				res_count  = n_active;
			end
			MODE_ALLOC: begin
				if (found_q) begin
					res_status = 1'b0;
					res_addr   = hit_addr_q;
					res_count  = nfree_q - CNT_W'(1);
				end
			end
			MODE_FREE: begin
				if (found_q && hit_used_q) begin
					res_status = 1'b0;
					res_count  = nfree_q + CNT_W'(1);
				end
			end
			default: begin
				res_status = 1'b1;
			end
		endcase
		// acc_q ends at base + n * size, unwrapped
		res_region = (addr_q >= base_q) && ({1'b0, addr_q} < acc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= RST_BASE;
			size_q  <= RST_SIZE;
			count_q <= RST_COUNT;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BASE:  base_q  <= cfg_data;
				REG_SIZE:  size_q  <= cfg_data[SIZE_W-1:0];
				REG_COUNT: count_q <= cfg_data[CNT_W-1:0];
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.finish) begin
			case (mode_q)
				MODE_CLEAR: begin
					for (int i = 0; i < MAX_BLOCKS; i++) begin
						if (CNT_W'(i) < n_active) used_q[i] <= 1'b0;
					end
				end
				MODE_ALLOC: begin
					if (found_q) used_q[hit_idx_q] <= 1'b1;
				end
				MODE_FREE: begin
					if (found_q && hit_used_q) used_q[hit_idx_q] <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (cmd.start) begin
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (cmd.step) begin
			idx_q <= idx_q + CNT_W'(1);
			if (hit) found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mode_q  <= req_mode;
			addr_q  <= req_address;
			acc_q   <= {1'b0, base_q};
			nfree_q <= '0;
		end else if (cmd.step) begin
			acc_q   <= acc_q + ACC_W'(size_q);
			nfree_q <= nfree_q + CNT_W'(!cur_used);
			if (hit) begin
				hit_idx_q  <= idx_q[IDX_W-1:0];
				hit_addr_q <= acc_q[ADDR_W-1:0];
				hit_used_q <= cur_used;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_status_q <= res_status;
			out_addr_q   <= res_addr;
			out_count_q  <= res_count;
			out_region_q <= res_region;
		end
	end

	assign out_valid         = out_valid_q;
	assign out_status        = out_status_q;
	assign out_block_address = out_addr_q;
	assign out_free_count    = out_count_q;
	assign out_in_region     = out_region_q;

endmodule

@@ hw/rtl/fixed_block_allocator.sv @@
// Top level of the fixed-size block pool allocator.
`timescale 1ns / 1ps

// Pool of equal-sized blocks with one used flag each (built capacity MAX_BLOCKS
// = 64). A request is clear (mode 0), alloc (mode 1, lowest free block) or free
// (mode 2, exact block address). Every request walks the active blocks one per
// cycle through a shared address accumulator, counting free flags and looking
// for the first free or matching block; the flags are updated when the walk
// ends. The walk covers block_count blocks, capped at 64. The controller
// accepts a request in idle, walks in scan and loads the result into the
// output register in finish, then returns to idle; the next request is
// accepted only after that. A result that is not taken stalls
// the load of the following one. Configuration
// writes (index 0 base_address, 1 block_size, 2 block_count) must be done
// while no request is in progress; they leave the used flags untouched.
// Failure (status 1) covers pool full, unknown address, block already free and
// the unused mode code 3.

module fixed_block_allocator import fba_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [1:0] mode, [33:2] address, rest zero
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // [0] status, [32:1] block_address,
	                                   // [39:33] free_count, [40] in_region
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	fba_cmd_t  cmd;
	fba_stat_t stat;

	logic              res_status;
	logic [ADDR_W-1:0] res_addr;
	logic [CNT_W-1:0]  res_count;
	logic              res_region;

	// registers are always writable
	assign cfg_ready = 1'b1;

	fba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fba_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.req_mode          (s_axis_tdata[1:0]),
		.req_address       (s_axis_tdata[33:2]),
		.cmd               (cmd),
		.stat              (stat),
		.out_ready         (m_axis_tready),
		.out_valid         (m_axis_tvalid),
		.out_status        (res_status),
		.out_block_address (res_addr),
		.out_free_count    (res_count),
		.out_in_region     (res_region)
	);

	assign m_axis_tdata = {7'b0, res_region, res_count, res_addr, res_status};

endmodule

@@ dv/fixed_block_allocator_tb.sv @@
// Self-checking testbench for the fixed-size block pool allocator.
`timescale 1ns / 1ps

module fixed_block_allocator_tb;
	import fba_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;  // spare mode code, must fail
	localparam logic       STATUS_OK   = 1'b0;
	localparam logic       STATUS_FAIL = 1'b1;
	localparam int         ITEM_TARGET = 550;
	localparam int         CYCLE_LIMIT = 500_000;
	localparam int         TAIL_CYCLES = 80;     // longer than one worst-case request

	typedef struct packed {
		logic              status;
		logic [ADDR_W-1:0] block_address;
		logic [CNT_W-1:0]  free_count;
		logic              in_region;
	} pool_result_t;

	// Directed row: a register write or a request, with an optional
	// hand-written result; rows without one go through the predictor.
	typedef struct packed {
		logic         is_cfg;
		logic [1:0]   code;   // mode, or register index
		logic [31:0]  value;  // address, or register data
		logic         literal;
		pool_result_t want;
	} plan_row_t;

	localparam logic         ROW_REQ  = 1'b0;
	localparam logic         ROW_CFG  = 1'b1;
	localparam logic         BY_HAND  = 1'b1;
	localparam logic         BY_MODEL = 1'b0;
	localparam pool_result_t NO_WANT  = '0;

	localparam int PLAN_ROWS = 34;
	localparam plan_row_t DIRECTED [PLAN_ROWS] = '{
		// reset pool: base 0, 16-byte blocks, 64 blocks
		{ROW_REQ, MODE_ALLOC, 32'h0000_0000, BY_HAND, STATUS_OK, 32'h0000_0000, 7'd63, 1'b1},
		{ROW_REQ, MODE_ALLOC, 32'hFFFF_FFFF, BY_HAND, STATUS_OK, 32'h0000_0010, 7'd62, 1'b0},
		{ROW_REQ, MODE_FREE,  32'h0000_0010, BY_HAND, STATUS_OK, 32'h0000_0000, 7'd63, 1'b1},
		// already free, misaligned, past the pool end
		{ROW_REQ, MODE_FREE,  32'h0000_0010, BY_HAND, STATUS_FAIL, 32'h0, 7'd63, 1'b1},
		{ROW_REQ, MODE_FREE,  32'h0000_0011, BY_HAND, STATUS_FAIL, 32'h0, 7'd63, 1'b1},
		{ROW_REQ, MODE_FREE,  32'h0000_0400, BY_HAND, STATUS_FAIL, 32'h0, 7'd63, 1'b0},
		{ROW_REQ, MODE_UNUSED, 32'h0000_03FF, BY_HAND, STATUS_FAIL, 32'h0, 7'd63, 1'b1},
		{ROW_REQ, MODE_CLEAR, 32'h0000_0005, BY_HAND, STATUS_OK, 32'h0, 7'd64, 1'b1},
		// top of address space: block 1 wraps, region end passes 2^32
		{ROW_CFG, REG_COUNT, 32'd2,         BY_MODEL, NO_WANT},
		{ROW_CFG, REG_SIZE,  32'h0000_FFFF, BY_MODEL, NO_WANT},
		{ROW_CFG, REG_BASE,  32'hFFFF_FFFF, BY_MODEL, NO_WANT},
		{ROW_REQ, MODE_ALLOC, 32'hFFFF_FFFF, BY_MODEL, NO_WANT},
		{ROW_REQ, MODE_ALLOC, 32'h0000_FFFE, BY_MODEL, NO_WANT},
		{ROW_REQ, MODE_ALLOC, 32'h0000_0000, BY_MODEL, NO_WANT},
		{ROW_REQ, MODE_FREE,  32'h0000_FFFE, BY_MODEL, NO_WANT},
		{ROW_REQ, MODE_FREE,  32'hFFFF_FFFF, BY_MODEL, NO_WANT},
		// empty pool
		{ROW_CFG, REG_COUNT, 32'd0, BY_MODEL, NO_WANT},
		{ROW_REQ, MODE_ALLOC, 32'hFFFF_FFFF, BY_HAND, STATUS_FAIL, 32'h0, 7'd0, 1'b0},
		{ROW_REQ, MODE_FREE,  32'hFFFF_FFFF, BY_HAND, STATUS_FAIL, 32'h0, 7'd0, 1'b0},
		// count above capacity, zero block size: every block at base
		{ROW_CFG, REG_COUNT, 32'd127,       BY_MODEL, NO_WANT},
		{ROW_CFG, REG_SIZE,  32'd0,         BY_MODEL, NO_WANT},
		{ROW_CFG, REG_BASE,  32'h0000_1234, BY_MODEL, NO_WANT},
		{ROW_REQ, MODE_ALLOC, 32'h0000_1234, BY_MODEL, NO_WANT},
		{ROW_REQ, MODE_FREE,  32'h0000_1234, BY_MODEL, NO_WANT},
		{ROW_REQ, MODE_FREE,  32'h0000_1234, BY_MODEL, NO_WANT},
		{ROW_REQ, MODE_ALLOC, 32'h0000_0000, BY_MODEL, NO_WANT},
		{ROW_REQ, MODE_ALLOC, 32'h0000_0000, BY_MODEL, NO_WANT},
		{ROW_REQ, MODE_FREE,  32'h0000_1234, BY_MODEL, NO_WANT},
		{ROW_REQ, MODE_CLEAR, 32'hFFFF_FFFF, BY_MODEL, NO_WANT},
		// single one-byte block
		{ROW_CFG, REG_BASE,  32'd0, BY_MODEL, NO_WANT},
		{ROW_CFG, REG_SIZE,  32'd1, BY_MODEL, NO_WANT},
		{ROW_CFG, REG_COUNT, 32'd1, BY_MODEL, NO_WANT},
		{ROW_REQ, MODE_ALLOC, 32'h0000_0000, BY_MODEL, NO_WANT},
		{ROW_REQ, MODE_ALLOC, 32'h0000_0001, BY_MODEL, NO_WANT}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;   // [1:0] mode, [33:2] address, rest zero
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;   // [0] status, [32:1] block_address,
	                             // [39:33] free_count, [40] in_region
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	// predictor state
	logic [ADDR_W-1:0]     pool_base;
	logic [SIZE_W-1:0]     pool_size;
	logic [CNT_W-1:0]      pool_count;
	logic [MAX_BLOCKS-1:0] used_map;

	pool_result_t pending_results [$];
	pool_result_t seen_result;
	pool_result_t oldest_result;
	int           mismatches  = 0;
	int           cycle_count = 0;
	int           rx_hold     = 0;
	bit           rx_steady   = 1'b0;

	fixed_block_allocator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned active_count();
		return (pool_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(pool_count);
	endfunction

	function automatic logic [ADDR_W-1:0] slot_address(input int unsigned slot);
		return pool_base + ADDR_W'(slot) * ADDR_W'(pool_size);
	endfunction

	// First-fit pool behavior for one request; updates used_map.
	function automatic pool_result_t allocator_outcome(input logic [1:0] mode,
			input logic [ADDR_W-1:0] addr);
		pool_result_t res;
		int unsigned  n;
		int unsigned  nfree;
		bit           hit;
		logic [63:0]  region_end;
		n = active_count();
		res = '0;
		res.status = STATUS_FAIL;
		hit = 1'b0;
		case (mode)
			MODE_CLEAR: begin
				for (int i = 0; i < n; i++)
					used_map[i] = 1'b0;
				res.status = STATUS_OK;
			end
			MODE_ALLOC: begin
				for (int i = 0; i < n && !hit; i++)
					if (!used_map[i]) begin
						used_map[i] = 1'b1;
						res.block_address = slot_address(i);
						res.status = STATUS_OK;
						hit = 1'b1;
					end
			end
			MODE_FREE: begin
				// lowest matching block decides, even when it is already free
				for (int i = 0; i < n && !hit; i++)
					if (slot_address(i) == addr) begin
						hit = 1'b1;
						if (used_map[i]) begin
							used_map[i] = 1'b0;
							res.status = STATUS_OK;
						end
					end
			end
			default: ;
		endcase
		nfree = 0;
		for (int i = 0; i < n; i++)
			if (!used_map[i])
				nfree++;
		res.free_count = CNT_W'(nfree);
		// region end is not wrapped
		region_end = 64'(pool_base) + 64'(n) * 64'(pool_size);
		res.in_region = (64'(addr) >= 64'(pool_base)) && (64'(addr) < region_end);
		return res;
	endfunction

	function automatic bit field_ok(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// Result side: compare with the oldest expectation, then pick the next
	// ready level (mostly short stalls, now and then a long one).
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_result.status        = m_axis_tdata[0];
			seen_result.block_address = m_axis_tdata[32:1];
			seen_result.free_count    = m_axis_tdata[39:33];
			seen_result.in_region     = m_axis_tdata[40];
			if (pending_results.size() == 0) begin
				$error("result with no request pending: 0x%0h", m_axis_tdata);
				mismatches++;
			end else begin
				oldest_result = pending_results.pop_front();
				if (!field_ok("status", 32'(oldest_result.status),
						32'(seen_result.status)))
					mismatches++;
				if (!field_ok("block_address", oldest_result.block_address,
						seen_result.block_address))
					mismatches++;
				if (!field_ok("free_count", 32'(oldest_result.free_count),
						32'(seen_result.free_count)))
					mismatches++;
				if (!field_ok("in_region", 32'(oldest_result.in_region),
						32'(seen_result.in_region)))
					mismatches++;
			end
		end
		if (rx_hold > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold--;
		end else if (rx_steady || $urandom_range(99) < 70) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= 1'b0;
			rx_hold = ($urandom_range(9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
		end
	end

	task automatic issue_request(input logic [1:0] mode, input logic [ADDR_W-1:0] addr,
			input logic by_hand, input pool_result_t hand_result);
		pool_result_t predicted;
		cfg_valid     <= 1'b0;
		s_axis_tdata  <= {6'b0, addr, mode};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predicted = allocator_outcome(mode, addr);
		pending_results.push_back(by_hand ? hand_result : predicted);
	endtask

	// Leaves cfg_valid high so back-to-back writes need no re-raise.
	task automatic write_register(input logic [1:0] index, input logic [31:0] value);
		cfg_index <= index;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (index)
			REG_BASE:  pool_base  = value;
			REG_SIZE:  pool_size  = value[SIZE_W-1:0];
			REG_COUNT: pool_count = value[CNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic drain_pool();
		s_axis_tvalid <= 1'b0;
		cfg_valid     <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic sender_gap(input bit steady);
		int gap;
		gap = 0;
		if (!steady) begin
			if ($urandom_range(99) >= 65)
				gap = ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int               items_sent;
		int               phase_len;
		int               pick;
		int               slot;
		int unsigned      n;
		bit               tx_steady;
		bit               prev_cfg;
		logic [1:0]       mode;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] probe;
		logic [31:0]      base_val;
		logic [31:0]      size_val;
		logic [31:0]      count_val;

		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_BASE;
		cfg_data      <= '0;
		pool_base  = RST_BASE;
		pool_size  = RST_SIZE;
		pool_count = RST_COUNT;
		used_map   = '0;
		items_sent = 0;
		prev_cfg   = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		for (int k = 0; k < PLAN_ROWS; k++) begin
			if (DIRECTED[k].is_cfg) begin
				if (!prev_cfg)
					drain_pool();
				write_register(DIRECTED[k].code, DIRECTED[k].value);
			end else begin
				issue_request(DIRECTED[k].code, DIRECTED[k].value,
					DIRECTED[k].literal, DIRECTED[k].want);
				items_sent++;
			end
			prev_cfg = DIRECTED[k].is_cfg;
		end

		// random phases, each with its own pool layout
		while (items_sent < ITEM_TARGET) begin
			drain_pool();
			rx_steady = ($urandom_range(3) == 0);
			tx_steady = ($urandom_range(3) == 0);

			pick = $urandom_range(99);
			if (pick < 25)      base_val = 32'h0;
			else if (pick < 55) base_val = $urandom;
			else if (pick < 75) base_val = 32'hFFFF_FFFF - $urandom_range(0, 4096);
			else                base_val = $urandom & 32'hFFFF_F000;

			pick = $urandom_range(99);
			if (pick < 8)       size_val = 32'd0;
			else if (pick < 48) size_val = $urandom_range(1, 8);
			else if (pick < 78) size_val = $urandom_range(9, 4096);
			else if (pick < 88) size_val = 32'h0000_FFFF;
			else                size_val = $urandom_range(1, 65535);

			pick = $urandom_range(99);
			if (pick < 5)       count_val = 32'd0;
			else if (pick < 50) count_val = $urandom_range(1, 8);
			else if (pick < 82) count_val = $urandom_range(9, 63);
			else if (pick < 90) count_val = 32'd64;
			else                count_val = $urandom_range(65, 127);

			write_register(REG_BASE, base_val);
			write_register(REG_SIZE, size_val);
			write_register(REG_COUNT, count_val);

			phase_len = $urandom_range(25, 60);
			repeat (phase_len) begin
				// hold off now and then until the pool is quiet
				if ($urandom_range(49) == 0)
					drain_pool();
				n = active_count();
				pick = $urandom_range(2);
				if (pick == 0)      probe = $urandom;
				else if (pick == 1) probe = slot_address($urandom_range(0, 64));
				else                probe = pool_base - 1 + $urandom_range(0, 2);

				slot = -1;
				pick = $urandom_range(63);
				for (int j = 0; j < n; j++)
					if (slot < 0 && used_map[(pick + j) % n])
						slot = (pick + j) % n;

				pick = $urandom_range(99);
				if (pick < 42) begin
					mode = MODE_ALLOC;
					addr = probe;
				end else if (pick < 70) begin
					// release of a block in use, or of any slot when none is in use
					mode = MODE_FREE;
					addr = (slot >= 0) ? slot_address(slot) : slot_address($urandom_range(0, n));
				end else if (pick < 80) begin
					mode = MODE_FREE;
					addr = slot_address($urandom_range(0, n));
				end else if (pick < 87) begin
					mode = MODE_FREE;
					addr = slot_address($urandom_range(0, n)) + $urandom_range(1, 3);
				end else if (pick < 93) begin
					mode = MODE_FREE;
					addr = $urandom;
				end else if (pick < 97) begin
					mode = MODE_CLEAR;
					addr = probe;
				end else begin
					mode = MODE_UNUSED;
					addr = probe;
				end

				issue_request(mode, addr, BY_MODEL, NO_WANT);
				items_sent++;
				sender_gap(tx_steady);
			end
		end

		drain_pool();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
